/* rtl/range_add_difference_array_macros.svh */
// Assertion macros shared by the range-add engine RTL.
// RAD_ASSERT checks a property on the rising clock edge, disabled while reset is high.
// RAD_ASSERT_NR checks a property on the rising clock edge with no reset qualifier.
`ifndef RANGE_ADD_DIFFERENCE_ARRAY_MACROS_SVH
`define RANGE_ADD_DIFFERENCE_ARRAY_MACROS_SVH
`ifndef SYNTHESIS
`define RAD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RAD_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAD_ASSERT(lbl, clk, rst, prop, msg)
`define RAD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* rtl/rad_pkg.sv */
// ---------------------------------------------------------------------------
// rad_pkg: shared types and constants of the range-add engine
// Field widths, command format passed from front to back, status group.
// ---------------------------------------------------------------------------
package rad_pkg;

   localparam int MAX_FLIGHTS_DEF  = 1024;
   localparam int MAX_BOOKINGS_DEF = 1024;

   localparam int IDX_W   = 11;   // index fields and count register
   localparam int SEATS_W = 16;
   localparam int TOTAL_W = 26;
   localparam int DELTA_W = 28;   // store entry
   localparam int SUM_W   = 27;   // running prefix sum
   localparam int SLOT_W  = 16;   // slot field, wide enough for the largest store

   localparam logic [IDX_W-1:0] FLIGHT_COUNT_RST = 11'd1024;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_BOOK = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   addr_a;   // booking start slot, or slot to read
      logic [SLOT_W-1:0]   addr_b;   // slot just past the range end
      logic                has_b;
      logic [SEATS_W-1:0]  amount;
      logic [IDX_W-1:0]    flight;
      logic                is_last;
      logic                dropped;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

/* rtl/rad_queue.sv */
// ---------------------------------------------------------------------------
// rad_queue: command queue between front and back
// Small register FIFO; push when not full, pop when not empty.
// ---------------------------------------------------------------------------
`include "range_add_difference_array_macros.svh"

module rad_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rad_pkg::cmd_type push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output rad_pkg::cmd_type pop_data
);

   rad_pkg::cmd_type                  entry_ff [rad_pkg::QUEUE_DEPTH];
   logic [rad_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [rad_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [rad_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign push_ready = (count_ff != rad_pkg::QCNT_W'(rad_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RAD_ASSERT(a_q_no_overflow, clock, reset, push |-> push_ready, "push into a full queue")
   `RAD_ASSERT(a_q_no_underflow, clock, reset, pop |-> pop_valid, "pop from an empty queue")
   `RAD_ASSERT(a_q_count_up, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count did not advance on push")

endmodule

/* rtl/rad_front.sv */
// ---------------------------------------------------------------------------
// rad_front: item intake and classification
// Holds the count register, read position, booking tally and dropped flag;
// checks bookings, builds store commands and pushes them into the queue.
// ---------------------------------------------------------------------------
module rad_front #(
   parameter int MAX_FLIGHTS  = rad_pkg::MAX_FLIGHTS_DEF,
   parameter int MAX_BOOKINGS = rad_pkg::MAX_BOOKINGS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [rad_pkg::IDX_W-1:0]   req_first_flight,
   input  logic [rad_pkg::IDX_W-1:0]   req_last_flight,
   input  logic [rad_pkg::SEATS_W-1:0] req_seats,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rad_pkg::IDX_W-1:0]   csr_flight_count,
   input  rad_pkg::status_type         back_status,
   input  logic                        q_ready,
   output logic                        q_push,
   output rad_pkg::cmd_type            q_data
);

   localparam int AW = $clog2(MAX_FLIGHTS);
   localparam int CW = ($clog2(MAX_FLIGHTS + 1) > rad_pkg::IDX_W) ?
                       $clog2(MAX_FLIGHTS + 1) : rad_pkg::IDX_W;
   localparam int TW = $clog2(MAX_BOOKINGS + 1);
   localparam logic MODE_READ = 1'b1;

   logic [rad_pkg::IDX_W-1:0] flight_count_ff, flight_count_in;
   logic [rad_pkg::IDX_W-1:0] read_index_ff, read_index_in;
   logic [TW-1:0]             tally_ff, tally_in;
   logic                      dropped_ff, dropped_in;

   logic [CW-1:0] max_f, fc, n, ri, idx, next_idx, first_w, last_w, rd_slot, first_slot;
   logic          book_ok, final_read, accept;

   assign csr_ready = 1'b1;
   assign req_ready = q_ready && !back_status.clearing;
   assign accept    = req_valid && req_ready;

   always_comb begin
      max_f      = CW'(MAX_FLIGHTS);
      fc         = CW'(flight_count_ff);
      if (fc == '0) begin
         n = CW'(1);
      end else if (fc > max_f) begin
         n = max_f;
      end else begin
         n = fc;
      end
      ri         = CW'(read_index_ff);
      idx        = (ri == '0 || ri > max_f) ? CW'(1) : ri;
      next_idx   = idx + CW'(1);
      rd_slot    = idx - CW'(1);
      final_read = (idx >= n);
      first_w    = CW'(req_first_flight);
      last_w     = CW'(req_last_flight);
      first_slot = first_w - CW'(1);
      book_ok    = (first_w != '0) && (first_w <= last_w) && (last_w <= n)
                   && (tally_ff < TW'(MAX_BOOKINGS))
                   && (read_index_ff == rad_pkg::IDX_W'(1));
   end

   always_comb begin
      q_data.amount  = req_seats;
      q_data.flight  = idx[rad_pkg::IDX_W-1:0];
      q_data.is_last = final_read;
      q_data.dropped = dropped_ff;
      if (req_mode == MODE_READ) begin
         q_data.op     = rad_pkg::OP_READ;
         q_data.addr_a = rad_pkg::SLOT_W'(rd_slot[AW-1:0]);
         q_data.addr_b = '0;
         q_data.has_b  = 1'b0;
      end else begin
         q_data.op     = rad_pkg::OP_BOOK;
         q_data.addr_a = rad_pkg::SLOT_W'(first_slot[AW-1:0]);
         q_data.addr_b = rad_pkg::SLOT_W'(last_w[AW-1:0]);
         q_data.has_b  = (last_w < n);
      end
      q_push = accept && ((req_mode == MODE_READ) || book_ok);
   end

   always_comb begin
      flight_count_in = csr_valid ? csr_flight_count : flight_count_ff;
      read_index_in   = read_index_ff;
      tally_in        = tally_ff;
      dropped_in      = dropped_ff;
      if (accept) begin
         if (req_mode == MODE_READ) begin
            if (final_read) begin
               // end of job: start over
               read_index_in = rad_pkg::IDX_W'(1);
               tally_in      = '0;
               dropped_in    = 1'b0;
            end else begin
               read_index_in = next_idx[rad_pkg::IDX_W-1:0];
            end
         end else if (book_ok) begin
            tally_in = tally_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_count_ff <= rad_pkg::FLIGHT_COUNT_RST;
         read_index_ff   <= rad_pkg::IDX_W'(1);
         tally_ff        <= '0;
         dropped_ff      <= 1'b0;
      end else begin
         flight_count_ff <= flight_count_in;
         read_index_ff   <= read_index_in;
         tally_ff        <= tally_in;
         dropped_ff      <= dropped_in;
      end
   end

endmodule

/* rtl/rad_back.sv */
// ---------------------------------------------------------------------------
// rad_back: store update engine
// Runs read-modify-write cycles on the single-port difference store, keeps
// the running prefix sum and drives the result register. Clears the store
// after reset.
// ---------------------------------------------------------------------------
`include "range_add_difference_array_macros.svh"

module rad_back #(
   parameter int MAX_FLIGHTS = rad_pkg::MAX_FLIGHTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  rad_pkg::cmd_type            q_data,
   output logic                        q_pop,
   output rad_pkg::status_type         back_status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rad_pkg::IDX_W-1:0]   rsp_flight,
   output logic [rad_pkg::TOTAL_W-1:0] rsp_total,
   output logic                        rsp_is_last,
   output logic                        rsp_dropped
);

   localparam int AW = $clog2(MAX_FLIGHTS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_FLIGHTS - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_WRITE
   } state_type;

   state_type                   state_ff, state_in;
   rad_pkg::cmd_type            cur_ff, cur_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   logic                        phase_b_ff, phase_b_in;
   logic [rad_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rad_pkg::IDX_W-1:0]   rsp_flight_ff, rsp_flight_in;
   logic [rad_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                        rsp_is_last_ff, rsp_is_last_in;
   logic                        rsp_dropped_ff, rsp_dropped_in;

   logic [rad_pkg::DELTA_W-1:0] delta_mem_ff [MAX_FLIGHTS];
   logic [rad_pkg::DELTA_W-1:0] mem_rd_ff;
   logic [rad_pkg::DELTA_W-1:0] mem_wdata, amount_w;
   logic [rad_pkg::SUM_W-1:0]   sum_add;
   logic [AW-1:0]               mem_addr;
   logic                        mem_we, mem_rd_en, is_read, out_free, rsp_load;

   assign back_status.clearing = (state_ff == S_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_flight  = rsp_flight_ff;
   assign rsp_total   = rsp_total_ff;
   assign rsp_is_last = rsp_is_last_ff;
   assign rsp_dropped = rsp_dropped_ff;

   assign mem_addr = (state_ff == S_CLEAR) ? clr_addr_ff : addr_ff;
   assign is_read  = (cur_ff.op == rad_pkg::OP_READ);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign amount_w = rad_pkg::DELTA_W'(cur_ff.amount);
   // sign extension of the entry drops out modulo the sum width
   assign sum_add  = sum_ff + mem_rd_ff[rad_pkg::SUM_W-1:0];

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      addr_in        = addr_ff;
      clr_addr_in    = clr_addr_ff;
      phase_b_in     = phase_b_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_flight_in  = rsp_flight_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_is_last_in = rsp_is_last_ff;
      rsp_dropped_in = rsp_dropped_ff;
      q_pop          = 1'b0;
      mem_we         = 1'b0;
      mem_rd_en      = 1'b0;
      mem_wdata      = '0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               cur_in     = q_data;
               addr_in    = q_data.addr_a[AW-1:0];
               phase_b_in = 1'b0;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            mem_rd_en = 1'b1;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            // hold a read until the result register can take it
            if (!is_read || out_free) begin
               mem_we = 1'b1;
               if (is_read) begin
                  mem_wdata      = '0;
                  rsp_load       = 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_flight_in  = cur_ff.flight;
                  rsp_total_in   = sum_add[rad_pkg::TOTAL_W-1:0];
                  rsp_is_last_in = cur_ff.is_last;
                  rsp_dropped_in = cur_ff.dropped;
                  sum_in         = cur_ff.is_last ? '0 : sum_add;
               end else if (phase_b_ff) begin
                  mem_wdata = mem_rd_ff - amount_w;
               end else begin
                  mem_wdata = mem_rd_ff + amount_w;
               end
               if (!is_read && !phase_b_ff && cur_ff.has_b) begin
                  phase_b_in = 1'b1;
                  addr_in    = cur_ff.addr_b[AW-1:0];
                  state_in   = S_READ;
               end else if (q_valid) begin
                  q_pop      = 1'b1;
                  cur_in     = q_data;
                  addr_in    = q_data.addr_a[AW-1:0];
                  phase_b_in = 1'b0;
                  state_in   = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         phase_b_ff   <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         phase_b_ff   <= phase_b_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff         <= cur_in;
      addr_ff        <= addr_in;
      rsp_flight_ff  <= rsp_flight_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_is_last_ff <= rsp_is_last_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         delta_mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_rd_en) begin
         mem_rd_ff <= delta_mem_ff[mem_addr];
      end
   end

   `RAD_ASSERT(a_no_pop_in_clear, clock, reset, (state_ff == S_CLEAR) |-> !q_pop, "queue popped during store clear")
   `RAD_ASSERT(a_rsp_no_overwrite, clock, reset, rsp_load |-> out_free, "result register overwritten before transfer")
   `RAD_ASSERT(a_phase_b_booking, clock, reset, phase_b_ff |-> (cur_ff.op == rad_pkg::OP_BOOK && cur_ff.has_b), "far-end update without a booking")

endmodule

/* rtl/range_add_difference_array.sv */
// Range-add engine on a difference store.
// Input channel req_*: req_mode 0 books req_seats over indices req_first_flight to
// req_last_flight; req_mode 1 reads the total of the next index in order. An item
// transfers when req_valid and req_ready are both high.
// Result channel rsp_*: one result per read, none per booking; a result transfers
// when rsp_valid and rsp_ready are both high.
// Config channel csr_*: csr_flight_count sets the index count of the job; always ready.
// Store engine: a read is one read-modify-write of the single-port store, a booking
// two (one when the range ends at the final index), each a read state then a write
// state. A rejected booking is taken at intake and makes no store access.
// A read passes the queue, the read and write states and then the result register.
// A two-entry command queue lets intake run ahead of the store engine.
// Reset: the store is cleared one entry per cycle; req_ready stays low for that pass
// while config writes are still taken.
// Receiver stall: a held result blocks the next read in the store engine; intake
// continues until the queue is full, then req_ready drops.
// ---------------------------------------------------------------------------
// range_add_difference_array: top level of the range-add engine
// Joins intake front, command queue and store engine.
// ---------------------------------------------------------------------------
module range_add_difference_array #(
   parameter int MAX_FLIGHTS  = rad_pkg::MAX_FLIGHTS_DEF,
   parameter int MAX_BOOKINGS = rad_pkg::MAX_BOOKINGS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [rad_pkg::IDX_W-1:0]   req_first_flight,
   input  logic [rad_pkg::IDX_W-1:0]   req_last_flight,
   input  logic [rad_pkg::SEATS_W-1:0] req_seats,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rad_pkg::IDX_W-1:0]   rsp_flight,
   output logic [rad_pkg::TOTAL_W-1:0] rsp_total,
   output logic                        rsp_is_last,
   output logic                        rsp_dropped,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rad_pkg::IDX_W-1:0]   csr_flight_count
);

   rad_pkg::cmd_type    push_data, pop_data;
   rad_pkg::status_type back_status;
   logic                push, push_ready, pop, pop_valid;

   rad_front #(
      .MAX_FLIGHTS  (MAX_FLIGHTS),
      .MAX_BOOKINGS (MAX_BOOKINGS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_first_flight (req_first_flight),
      .req_last_flight  (req_last_flight),
      .req_seats        (req_seats),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_flight_count (csr_flight_count),
      .back_status      (back_status),
      .q_ready          (push_ready),
      .q_push           (push),
      .q_data           (push_data)
   );

   rad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   rad_back #(
      .MAX_FLIGHTS (MAX_FLIGHTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (pop_valid),
      .q_data      (pop_data),
      .q_pop       (pop),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_flight  (rsp_flight),
      .rsp_total   (rsp_total),
      .rsp_is_last (rsp_is_last),
      .rsp_dropped (rsp_dropped)
   );

endmodule

/* sim/tb_range_add_difference_array.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_range_add_difference_array: self-checking bench of the range-add engine
// Drives bookings and reads with random gaps and result stalls, keeps its
// own copy of the difference store and running sum, and checks each total,
// index, last flag and dropped flag in order.
// ---------------------------------------------------------------------------
module tb_range_add_difference_array;

   localparam int IDX_W   = rad_pkg::IDX_W;
   localparam int SEATS_W = rad_pkg::SEATS_W;
   localparam int TOTAL_W = rad_pkg::TOTAL_W;
   localparam int DELTA_W = rad_pkg::DELTA_W;
   localparam int SUM_W   = rad_pkg::SUM_W;

   localparam int ITEM_TARGET   = 1380;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef struct {
      logic [IDX_W-1:0]   flight;
      logic [TOTAL_W-1:0] total;
      logic               is_last;
      logic               dropped;
   } flight_total_type;

   // Seat ledger: difference store, prefix sum and job state, updated per transfer
   class booking_ledger_type;
      logic [DELTA_W-1:0] deltas [rad_pkg::MAX_FLIGHTS_DEF];
      logic [SUM_W-1:0]   run_sum;
      logic [IDX_W-1:0]   next_flight;
      int unsigned        booked;
      logic               job_dropped;
      logic [IDX_W-1:0]   count_reg;
      flight_total_type   expected_totals [$];
      int unsigned        mismatches;

      function new();
         foreach (deltas[i]) deltas[i] = '0;
         run_sum     = '0;
         next_flight = IDX_W'(1);
         booked      = 0;
         job_dropped = 1'b0;
         count_reg   = rad_pkg::FLIGHT_COUNT_RST;
         mismatches  = 0;
      endfunction

      function int unsigned job_size();
         if (count_reg == 0) return 1;
         if (count_reg > rad_pkg::MAX_FLIGHTS_DEF) return rad_pkg::MAX_FLIGHTS_DEF;
         return 32'(count_reg);
      endfunction

      function void set_count(logic [IDX_W-1:0] value);
         count_reg = value;
      endfunction

      function bit mid_job();
         return next_flight != 1;
      endfunction

      function int pending();
         return expected_totals.size();
      endfunction

      function void note_item(rad_pkg::op_type op, logic [IDX_W-1:0] first_idx,
                              logic [IDX_W-1:0] last_idx, logic [SEATS_W-1:0] seats);
         int unsigned      n;
         int unsigned      slot;
         flight_total_type res;
         n = job_size();
         if (op == rad_pkg::OP_BOOK) begin
            if (first_idx >= 1 && first_idx <= last_idx && last_idx <= n &&
                booked < rad_pkg::MAX_BOOKINGS_DEF && next_flight == 1) begin
               deltas[first_idx - 1] += seats;
               // a range that ends on the final index needs no closing entry
               if (last_idx < n) deltas[last_idx] -= seats;
               booked++;
            end else begin
               job_dropped = 1'b1;
            end
         end else begin
            slot = 32'(next_flight) - 1;
            // the low bits of the sign-extended entry are all a 27-bit sum needs
            run_sum += deltas[slot][SUM_W-1:0];
            deltas[slot] = '0;
            res.flight  = next_flight;
            res.total   = run_sum[TOTAL_W-1:0];
            res.is_last = (next_flight >= n);
            res.dropped = job_dropped;
            expected_totals.insert(expected_totals.size(), res);
            if (res.is_last) begin
               run_sum     = '0;
               next_flight = IDX_W'(1);
               booked      = 0;
               job_dropped = 1'b0;
            end else begin
               next_flight++;
            end
         end
      endfunction

      function void check_result(logic [IDX_W-1:0] flight, logic [TOTAL_W-1:0] total,
                                 logic is_last, logic dropped);
         flight_total_type want;
         if (expected_totals.size() == 0) begin
            $display("%0t: result with nothing expected: flight %0d total %0d",
                     $time, flight, total);
            mismatches++;
            return;
         end
         want = expected_totals.pop_front();
         if (flight !== want.flight) begin
            $display("%0t: flight mismatch: expected %0d, actual %0d",
                     $time, want.flight, flight);
            mismatches++;
         end
         if (total !== want.total) begin
            $display("%0t: total mismatch at flight %0d: expected %0d, actual %0d",
                     $time, want.flight, want.total, total);
            mismatches++;
         end
         if (is_last !== want.is_last) begin
            $display("%0t: is_last mismatch at flight %0d: expected %0d, actual %0d",
                     $time, want.flight, want.is_last, is_last);
            mismatches++;
         end
         if (dropped !== want.dropped) begin
            $display("%0t: dropped mismatch at flight %0d: expected %0d, actual %0d",
                     $time, want.flight, want.dropped, dropped);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_mode         = 1'b0;
   logic [IDX_W-1:0]     req_first_flight = '0;
   logic [IDX_W-1:0]     req_last_flight  = '0;
   logic [SEATS_W-1:0]   req_seats        = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [IDX_W-1:0]     rsp_flight;
   logic [TOTAL_W-1:0]   rsp_total;
   logic                 rsp_is_last;
   logic                 rsp_dropped;
   logic                 csr_valid        = 1'b0;
   logic                 csr_ready;
   logic [IDX_W-1:0]     csr_flight_count = '0;

   booking_ledger_type ledger;
   int unsigned        cycles      = 0;
   int unsigned        items_sent  = 0;
   int unsigned        stall_left  = 0;
   bit                 sender_gaps = 1'b1;
   bit                 rsp_stalls  = 1'b1;

   range_add_difference_array u_top (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_mode,
      .req_first_flight,
      .req_last_flight,
      .req_seats,
      .rsp_valid,
      .rsp_ready,
      .rsp_flight,
      .rsp_total,
      .rsp_is_last,
      .rsp_dropped,
      .csr_valid,
      .csr_ready,
      .csr_flight_count
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Check result transfers and pick the next receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_result(rsp_flight, rsp_total, rsp_is_last, rsp_dropped);
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(16, 60)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic pause_sender();
      int r;
      int gap;
      gap = 0;
      if (sender_gaps) begin
         r = $urandom_range(0, 99);
         if (r >= 90)
            gap = $urandom_range(8, 40);
         else if (r >= 55)
            gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic offer_request(rad_pkg::op_type op, logic [IDX_W-1:0] first_idx,
                                logic [IDX_W-1:0] last_idx, logic [SEATS_W-1:0] seats);
      req_valid        <= 1'b1;
      req_mode         <= op;
      req_first_flight <= first_idx;
      req_last_flight  <= last_idx;
      req_seats        <= seats;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_item(op, first_idx, last_idx, seats);
      items_sent++;
      pause_sender();
   endtask

   task automatic read_next_total();
      // unused payload carries random bits
      offer_request(rad_pkg::OP_READ, IDX_W'($urandom), IDX_W'($urandom),
                    SEATS_W'($urandom));
   endtask

   // Hold off until every total is back and queued bookings have drained
   task automatic wait_block_idle();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_flight_count(logic [IDX_W-1:0] value);
      wait_block_idle();
      csr_valid        <= 1'b1;
      csr_flight_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ledger.set_count(value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [SEATS_W-1:0] pick_seats();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return SEATS_W'($urandom);
      endcase
   endfunction

   function automatic void pick_range(input int unsigned n, input int noise_pct,
                                      output logic [IDX_W-1:0] first_idx,
                                      output logic [IDX_W-1:0] last_idx);
      if ($urandom_range(0, 99) < noise_pct) begin
         first_idx = IDX_W'($urandom);
         last_idx  = IDX_W'($urandom);
      end else begin
         first_idx = IDX_W'($urandom_range(1, n));
         last_idx  = IDX_W'($urandom_range(32'(first_idx), n));
      end
   endfunction

   // One job: set the count, book, then read until the final index comes out
   task automatic run_job(logic [IDX_W-1:0] count_val, int bookings, int noise_pct);
      int unsigned      n;
      int               cut_at;
      int               reads;
      logic [IDX_W-1:0] first_idx;
      logic [IDX_W-1:0] last_idx;
      set_flight_count(count_val);
      n = ledger.job_size();
      cut_at = 0;
      if (n > 64)
         cut_at = $urandom_range(8, 40);
      else if (n > 1 && $urandom_range(0, 4) == 0)
         cut_at = $urandom_range(1, n - 1);
      repeat (bookings) begin
         pick_range(n, noise_pct, first_idx, last_idx);
         offer_request(rad_pkg::OP_BOOK, first_idx, last_idx, pick_seats());
      end
      reads = 0;
      do begin
         if (cut_at != 0 && reads == cut_at) begin
            // change the count mid-job; a lower count leaves unread entries behind
            set_flight_count(IDX_W'($urandom_range(0, 20)));
         end else if (reads != 0 && $urandom_range(0, 19) == 0) begin
            pick_range(n, 50, first_idx, last_idx);
            offer_request(rad_pkg::OP_BOOK, first_idx, last_idx, pick_seats());
         end else if ($urandom_range(0, 49) == 0) begin
            wait_block_idle();
         end
         read_next_total();
         reads++;
      end while (ledger.mid_job());
   endtask

   initial begin
      int               sel;
      logic [IDX_W-1:0] count_val;
      ledger = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // count above the store size, full-range and bad bookings
      set_flight_count(11'd2047);
      offer_request(rad_pkg::OP_BOOK, 11'd1, 11'd1024, 16'hFFFF);
      offer_request(rad_pkg::OP_BOOK, 11'd0, 11'd5, 16'd7);
      offer_request(rad_pkg::OP_BOOK, 11'd2047, 11'd2047, 16'd0);
      offer_request(rad_pkg::OP_BOOK, 11'd9, 11'd3, 16'd1);
      offer_request(rad_pkg::OP_BOOK, 11'd1024, 11'd1024, 16'd1);
      offer_request(rad_pkg::OP_BOOK, 11'd2, 11'd1023, 16'hFFFF);
      // shrink before readout, leaving entries for later jobs
      set_flight_count(11'd3);
      repeat (3) read_next_total();
      // zero count acts as one
      set_flight_count(11'd0);
      offer_request(rad_pkg::OP_BOOK, 11'd1, 11'd1, 16'd0);
      offer_request(rad_pkg::OP_BOOK, 11'd1, 11'd2, 16'd3);
      read_next_total();
      // booking refused once readout has begun
      set_flight_count(11'd2);
      offer_request(rad_pkg::OP_BOOK, 11'd1, 11'd1, 16'd100);
      read_next_total();
      offer_request(rad_pkg::OP_BOOK, 11'd1, 11'd2, 16'd5);
      read_next_total();
      // read past a count lowered mid-job ends the job
      set_flight_count(11'd1024);
      offer_request(rad_pkg::OP_BOOK, 11'd1, 11'd1, 16'd1);
      read_next_total();
      read_next_total();
      set_flight_count(11'd1);
      read_next_total();

      // push past the per-job booking cap
      run_job(IDX_W'($urandom_range(2, 12)), rad_pkg::MAX_BOOKINGS_DEF + 36, 2);

      while (items_sent < ITEM_TARGET) begin
         sender_gaps = ($urandom_range(0, 3) != 0);
         rsp_stalls <= ($urandom_range(0, 3) != 0);
         sel = $urandom_range(0, 99);
         if (sel < 70)
            count_val = IDX_W'($urandom_range(1, 16));
         else if (sel < 78)
            count_val = 11'd0;
         else if (sel < 88)
            count_val = IDX_W'($urandom_range(17, 64));
         else if (sel < 92)
            count_val = 11'd1024;
         else if (sel < 95)
            count_val = 11'd2047;
         else
            count_val = IDX_W'($urandom);
         run_job(count_val, $urandom_range(0, 12), 15);
      end

      wait_block_idle();
      if (ledger.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* range_add_difference_array.f */
+incdir+rtl
rtl/rad_pkg.sv
rtl/rad_queue.sv
rtl/rad_front.sv
rtl/rad_back.sv
rtl/range_add_difference_array.sv
sim/tb_range_add_difference_array.sv
